// ===== src/sacl_pkg.sv =====
`default_nettype none
package sacl_pkg;

  // default geometry
  localparam int SETS_LOG2_DEF = 8;
  localparam int WAYS_DEF      = 4;
  localparam int ADDR_BITS_DEF = 32;

  // configuration port
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_SHIFT   = 1'd1;
  localparam logic [CFG_W-1:0] BLOCK_SHIFT_RST = 4'd5;
  localparam logic [CFG_W-1:0] SET_SHIFT_RST   = 4'd8;

  // access kind
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // statistics counters
  localparam int CNT_W   = 32;
  localparam int NUM_CNT = 8;
  localparam logic [2:0] CNT_READS      = 3'd0;
  localparam logic [2:0] CNT_WRITES     = 3'd1;
  localparam logic [2:0] CNT_READ_HITS  = 3'd2;
  localparam logic [2:0] CNT_WRITE_HITS = 3'd3;
  localparam logic [2:0] CNT_READ_MISS  = 3'd4;
  localparam logic [2:0] CNT_WRITE_MISS = 3'd5;
  localparam logic [2:0] CNT_EVICTS     = 3'd6;
  localparam logic [2:0] CNT_WBS        = 3'd7;

  // result packing: hit, evicted, write_back, way_used[2], miss_total, write_back_total
  localparam int OUT_W = 72;

  // one finished lookup, handed to the statistics block
  typedef struct packed {
    logic strobe;
    logic wr;
    logic hit;
    logic evicted;
    logic wb;
  } stat_evt_t;

endpackage
`default_nettype wire

// ===== src/sacl_stats.sv =====
`default_nettype none
module sacl_stats
  import sacl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire stat_evt_t        evt,
  output logic [CNT_W-1:0]      miss_total,
  output logic [CNT_W-1:0]      wb_total
);

  logic [CNT_W-1:0] cnt_r   [NUM_CNT];
  logic [CNT_W-1:0] cnt_nxt [NUM_CNT];
  logic [CNT_W-1:0] miss_total_r;
  logic [CNT_W-1:0] miss_total_nxt;
  logic [NUM_CNT-1:0] bump;
  logic [CNT_W:0]   miss_sum;

  // which counters move on this transaction
  always_comb begin
    bump = '0;
    if (evt.strobe) begin
      bump[evt.wr ? CNT_WRITES : CNT_READS] = 1'b1;
      if (evt.hit) begin
        bump[evt.wr ? CNT_WRITE_HITS : CNT_READ_HITS] = 1'b1;
      end else begin
        bump[evt.wr ? CNT_WRITE_MISS : CNT_READ_MISS] = 1'b1;
      end
      if (evt.evicted) begin
        bump[CNT_EVICTS] = 1'b1;
      end
      if (evt.wb) begin
        bump[CNT_WBS] = 1'b1;
      end
    end
  end

  // saturating increments
  always_comb begin
    for (int k = 0; k < NUM_CNT; k++) begin
      if (bump[k] && (cnt_r[k] != {CNT_W{1'b1}})) begin
        cnt_nxt[k] = cnt_r[k] + 1'b1;
      end else begin
        cnt_nxt[k] = cnt_r[k];
      end
    end
  end

  // saturating sum of read and write misses
  always_comb begin
    miss_sum = {1'b0, cnt_nxt[CNT_READ_MISS]} + {1'b0, cnt_nxt[CNT_WRITE_MISS]};
    miss_total_nxt = miss_sum[CNT_W] ? {CNT_W{1'b1}} : miss_sum[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CNT; k++) begin
        cnt_r[k] <= '0;
      end
      miss_total_r <= '0;
    end else if (evt.strobe) begin
      for (int k = 0; k < NUM_CNT; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
      miss_total_r <= miss_total_nxt;
    end
  end

  assign miss_total = miss_total_r;
  assign wb_total   = cnt_r[CNT_WBS];

endmodule
`default_nettype wire

// ===== src/set_assoc_cache_lru_wb.sv =====
// the set row of an accepted transaction is read into a register; the result register loads
//   from the lookup state once the output register is free; one transaction at a time, as a new
//   one is not accepted until the row memory read and the read-modify-write of that set row end
// reset: synchronous active low; a clearing pass then zeroes one set row per cycle, all
//   2**SETS_LOG2 rows (256 by default), with in_tready low; config writes are taken in every state
`default_nettype none
module set_assoc_cache_lru_wb
  import sacl_pkg::*;
#(
  parameter int SETS_LOG2 = SETS_LOG2_DEF,
  parameter int WAYS      = WAYS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  localparam int IN_W     = ((ADDR_BITS + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_W-1:0]      in_tdata,   // address
  input  wire logic                 in_tuser,   // opcode
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [OUT_W-1:0]          out_tdata,  // hit, evicted, write_back, way_used[1:0],
                                                // miss_total[31:0], write_back_total[31:0]
  // configuration
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int NSETS = 1 << SETS_LOG2;
  localparam int SETW  = (SETS_LOG2 > 0) ? SETS_LOG2 : 1;
  localparam int WAYW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGEW  = WAYW;
  localparam logic [AGEW-1:0] AGE_MAX = AGEW'(WAYS - 1);
  localparam logic [CFG_W-1:0] SS_MAX = CFG_W'(SETS_LOG2);

  typedef struct packed {
    logic                 valid;
    logic                 dirty;
    logic [AGEW-1:0]      age;
    logic [ADDR_BITS-1:0] tag;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0] block_shift_r;
  logic [CFG_W-1:0] set_shift_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_shift_r <= BLOCK_SHIFT_RST;
      set_shift_r   <= SET_SHIFT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BLOCK_SHIFT: block_shift_r <= cfg_wdata;
        CFG_SET_SHIFT:   set_shift_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // address split
  logic [ADDR_BITS-1:0] addr;
  logic [CFG_W-1:0]     ss_eff;
  logic [ADDR_BITS-1:0] blk;
  logic [ADDR_BITS-1:0] set_mask;
  logic [SETW-1:0]      set_idx;
  logic [ADDR_BITS-1:0] tag_in;

  always_comb begin
    addr     = in_tdata[ADDR_BITS-1:0];
    ss_eff   = (set_shift_r > SS_MAX) ? SS_MAX : set_shift_r;
    blk      = addr >> block_shift_r;
    set_mask = ~({ADDR_BITS{1'b1}} << ss_eff);
    set_idx  = SETW'(blk & set_mask);
    tag_in   = blk >> ss_eff;
  end

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // set row memory
  row_t            mem [NSETS];
  row_t            rd_row_r;
  logic            mem_we;
  logic [SETW-1:0] mem_waddr;
  row_t            mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_row_r <= mem[set_idx];
    end
  end

  // transaction held for the lookup
  logic [SETW-1:0]      set_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic                 wr_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      set_r <= set_idx;
      tag_r <= tag_in;
      wr_r  <= (in_tuser == OP_WRITE);
    end
  end

  // way compare, invalid way and lru victim search
  logic            hit;
  logic            have_inv;
  logic [WAYW-1:0] hit_way;
  logic [WAYW-1:0] inv_way;
  logic [WAYW-1:0] victim;
  logic            best_found;
  logic [AGEW-1:0] best_age;
  logic [WAYW-1:0] way;
  logic            evicted;
  logic            wb;

  always_comb begin
    hit        = 1'b0;
    have_inv   = 1'b0;
    hit_way    = '0;
    inv_way    = '0;
    victim     = '0;
    best_found = 1'b0;
    best_age   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!rd_row_r[w].valid) begin
        have_inv = 1'b1;
        inv_way  = WAYW'(w);
      end else begin
        if (rd_row_r[w].tag == tag_r) begin
          hit     = 1'b1;
          hit_way = WAYW'(w);
        end
        if (!best_found || (rd_row_r[w].age > best_age)) begin
          best_found = 1'b1;
          best_age   = rd_row_r[w].age;
          victim     = WAYW'(w);
        end
      end
    end
    if (hit) begin
      way = hit_way;
    end else if (have_inv) begin
      way = inv_way;
    end else begin
      way = victim;
    end
    evicted = !hit && !have_inv;
    wb      = evicted && rd_row_r[way].dirty;
  end

  // updated set row: age the younger ways, then place the used way
  logic            was_valid;
  logic [AGEW-1:0] old_age;
  row_t            row_nxt;

  always_comb begin
    was_valid = rd_row_r[way].valid;
    old_age   = rd_row_r[way].age;
    row_nxt   = rd_row_r;
    for (int v = 0; v < WAYS; v++) begin
      if ((WAYW'(v) != way) && rd_row_r[v].valid &&
          (!was_valid || (rd_row_r[v].age < old_age)) &&
          (rd_row_r[v].age < AGE_MAX)) begin
        row_nxt[v].age = rd_row_r[v].age + 1'b1;
      end
    end
    row_nxt[way].age = '0;
    if (hit) begin
      if (wr_r) begin
        row_nxt[way].dirty = 1'b1;
      end
    end else begin
      row_nxt[way].valid = 1'b1;
      row_nxt[way].tag   = tag_r;
      row_nxt[way].dirty = wr_r;
    end
  end

  logic [SETW-1:0] clr_idx_r;
  logic            out_valid_r;

  // finish the lookup once the output register is free
  logic finish;
  assign finish = (state_r == ST_LOOK) && (!out_valid_r || out_tready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = set_r;
    mem_wdata = row_nxt;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else if (finish) begin
      mem_we = 1'b1;
    end
  end

  // statistics
  stat_evt_t        evt;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] wb_total;

  always_comb begin
    evt.strobe  = finish;
    evt.wr      = wr_r;
    evt.hit     = hit;
    evt.evicted = evicted;
    evt.wb      = wb;
  end

  sacl_stats u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .evt        (evt),
    .miss_total (miss_total),
    .wb_total   (wb_total)
  );

  // sequencer and result register
  logic       hit_r;
  logic       evicted_r;
  logic       wb_r;
  logic [1:0] way_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == SETW'(NSETS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (finish) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      hit_r     <= hit;
      evicted_r <= evicted;
      wb_r      <= wb;
      way_r     <= 2'(way);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, wb_total, miss_total, way_r, wb_r, evicted_r, hit_r};

endmodule
`default_nettype wire

// ===== src/sacl_checker.sv =====
`default_nettype none
module sacl_checker
  import sacl_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // one access is looked up at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken during lookup");

  // a write-back only comes with an eviction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1])
    else $error("write-back without eviction");

  // a hit never evicts
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[1])
    else $error("eviction on a hit");

  // the write-back total never drops between results
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready ##1 out_tvalid |-> out_tdata[68:37] >= $past(out_tdata[68:37]))
    else $error("write-back total decreased");

endmodule

bind set_assoc_cache_lru_wb sacl_checker u_sacl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== bench/set_assoc_cache_lru_wb_tb.sv =====
module set_assoc_cache_lru_wb_tb
  import sacl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWAYS        = WAYS_DEF;
  localparam int NLINES       = (1 << SETS_LOG2_DEF) * NWAYS;
  localparam int RESET_CYCLES = 9;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HIST         = 16;
  localparam int PHASE_ITEMS  = 140;

  // result layout, lowest bit first: hit, evicted, write_back, way, miss total, wb total
  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] wb_total;
    logic [31:0] miss_total;
    logic [1:0]  way;
    logic        write_back;
    logic        evicted;
    logic        hit;
  } lookup_result_t;

  // tag store mirror, lru ranking and statistics; keeps the expected lookups in order
  class lru_cache_tracker;
    bit          way_valid[NLINES];
    bit [31:0]   way_tag[NLINES];
    bit          way_dirty[NLINES];
    int unsigned way_rank[NLINES];
    bit [31:0]   stat_cnt[NUM_CNT];
    bit [3:0]    blk_shift = BLOCK_SHIFT_RST;
    bit [3:0]    idx_shift = SET_SHIFT_RST;
    lookup_result_t awaited[$];
    int errors;
    int checked;

    function void configure(bit [3:0] bs, bit [3:0] ss);
      blk_shift = bs;
      idx_shift = ss;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void bump(logic [2:0] k);
      if (stat_cnt[k] != 32'hFFFF_FFFF) stat_cnt[k]++;
    endfunction

    // make one way of a set the most recent, aging the ones that were younger
    function void promote(int unsigned base, int unsigned w);
      bit          was_valid;
      int unsigned old_rank;
      was_valid = way_valid[base + w];
      old_rank  = way_rank[base + w];
      for (int v = 0; v < NWAYS; v++) begin
        if (v != w && way_valid[base + v]) begin
          if ((!was_valid || way_rank[base + v] < old_rank) && way_rank[base + v] < NWAYS - 1)
            way_rank[base + v]++;
        end
      end
      way_rank[base + w] = 0;
    endfunction

    // look up one accepted access, update the mirror and queue its result
    function void note_access(logic op, logic [31:0] addr);
      lookup_result_t res;
      int unsigned    eff_ss, base, way, victim, inv;
      int             best;
      bit             is_wr, have_inv;
      logic [31:0]    blk, set_idx, tag;
      logic [32:0]    msum;
      res      = '0;
      way      = 0;
      victim   = 0;
      inv      = 0;
      best     = -1;
      have_inv = 1'b0;
      is_wr    = (op == OP_WRITE);
      eff_ss   = (idx_shift > SETS_LOG2_DEF) ? SETS_LOG2_DEF : idx_shift;
      blk      = addr >> blk_shift;
      set_idx  = blk & ((32'd1 << eff_ss) - 32'd1);
      tag      = blk >> eff_ss;
      base     = set_idx * NWAYS;
      bump(is_wr ? CNT_WRITES : CNT_READS);

      // parallel compare: highest matching way wins, highest invalid way is the fill slot
      for (int w = 0; w < NWAYS; w++) begin
        if (!way_valid[base + w]) begin
          have_inv = 1'b1;
          inv      = w;
        end else begin
          if (way_tag[base + w] == tag) begin
            res.hit = 1'b1;
            way     = w;
          end
          if (int'(way_rank[base + w]) > best) begin
            best   = way_rank[base + w];
            victim = w;
          end
        end
      end

      if (res.hit) begin
        bump(is_wr ? CNT_WRITE_HITS : CNT_READ_HITS);
        if (is_wr) way_dirty[base + way] = 1'b1;
        promote(base, way);
      end else begin
        bump(is_wr ? CNT_WRITE_MISS : CNT_READ_MISS);
        if (have_inv) begin
          way = inv;
        end else begin
          way            = victim;
          res.evicted    = 1'b1;
          res.write_back = way_dirty[base + way];
          bump(CNT_EVICTS);
          if (res.write_back) bump(CNT_WBS);
        end
        promote(base, way);
        way_valid[base + way] = 1'b1;
        way_tag[base + way]   = tag;
        way_dirty[base + way] = is_wr;
      end

      msum           = {1'b0, stat_cnt[CNT_READ_MISS]} + {1'b0, stat_cnt[CNT_WRITE_MISS]};
      res.way        = 2'(way);
      res.miss_total = msum[32] ? 32'hFFFF_FFFF : msum[31:0];
      res.wb_total   = stat_cnt[CNT_WBS];
      awaited.push_back(res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] result %0d: %s is %0h, expected %0h", $time, checked, what, got, want);
      errors++;
    endtask

    // compare one result transaction with the oldest expected lookup
    task check_result(logic [OUT_W-1:0] data);
      lookup_result_t got, want;
      got = lookup_result_t'(data);
      checked++;
      if (awaited.size() == 0) begin
        report("spurious result, low word", data[31:0], 32'd0);
        return;
      end
      want = awaited.pop_front();
      if (got.hit !== want.hit) report("hit", got.hit, want.hit);
      if (got.evicted !== want.evicted) report("evicted", got.evicted, want.evicted);
      if (got.write_back !== want.write_back)
        report("write_back", got.write_back, want.write_back);
      if (got.way !== want.way) report("way_used", got.way, want.way);
      if (got.miss_total !== want.miss_total)
        report("miss_total", got.miss_total, want.miss_total);
      if (got.wb_total !== want.wb_total)
        report("write_back_total", got.wb_total, want.wb_total);
      if (got.pad !== 3'd0) report("padding", got.pad, 32'd0);
    endtask
  endclass

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;
  logic                 in_tuser   = OP_READ;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_BLOCK_SHIFT;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  lru_cache_tracker sb = new();

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  bit          hold_req      = 1'b0;
  int          quiet_cycles  = 0;
  logic [31:0] recent_addr[HIST] = '{default: '0};
  int          hist_ptr      = 0;

  set_assoc_cache_lru_wb u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one access after a random idle gap and wait for its transaction
  task automatic send_access(input logic op, input logic [31:0] addr);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_access(op, addr);
  endtask

  // mostly conflicting blocks in a few sets, some reuse, some fully random addresses
  function automatic logic [31:0] make_addr(input logic [3:0] bs, input logic [3:0] ss);
    logic [63:0] blk;
    logic [31:0] addr;
    int unsigned pick, ss_eff;
    pick   = $urandom_range(99);
    ss_eff = (ss > SETS_LOG2_DEF) ? SETS_LOG2_DEF : ss;
    if (pick < 15) begin
      addr = $urandom;
    end else if (pick < 40) begin
      addr = recent_addr[$urandom_range(HIST - 1)];
    end else begin
      blk  = (64'($urandom_range(5)) << ss_eff) |
             64'($urandom_range(3) & ((1 << ss_eff) - 1));
      addr = 32'((blk << bs) | 64'($urandom & ((32'd1 << bs) - 32'd1)));
    end
    recent_addr[hist_ptr] = addr;
    hist_ptr = (hist_ptr + 1) % HIST;
    return addr;
  endfunction

  // let every result come back, then give the pipeline time to settle
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [3:0] bs, input logic [3:0] ss);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_BLOCK_SHIFT;
    cfg_wdata <= bs;
    @(posedge clk);
    cfg_index <= CFG_SET_SHIFT;
    cfg_wdata <= ss;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.configure(bs, ss);
  endtask

  task automatic run_phase(input logic [3:0] bs, input logic [3:0] ss, input int snd,
                           input int rcv, input bit squeeze);
    logic op;
    wait_drained();
    set_geometry(bs, ss);
    send_idle_pct = snd;
    stall_pct     = rcv;
    if (squeeze) hold_req = 1'b1;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      op = $urandom_range(1) ? OP_WRITE : OP_READ;
      send_access(op, make_addr(bs, ss));
    end
    in_tvalid <= 1'b0;
  endtask

  // default geometry: one set filled, hits, clean and dirty evictions, address extremes
  task automatic run_directed();
    send_access(OP_WRITE, 32'h0000_0000);
    send_access(OP_READ,  32'h0000_2000);
    send_access(OP_READ,  32'h0000_4000);
    send_access(OP_WRITE, 32'h0000_6000);
    send_access(OP_READ,  32'h0000_001F);
    send_access(OP_READ,  32'h0000_8000);
    send_access(OP_WRITE, 32'h0000_4000);
    send_access(OP_READ,  32'h0000_A000);
    send_access(OP_READ,  32'h0000_C000);
    send_access(OP_READ,  32'h0000_E000);
    send_access(OP_READ,  32'h0000_2000);
    send_access(OP_WRITE, 32'hFFFF_FFFF);
    send_access(OP_READ,  32'hFFFF_FFFF);
    send_access(OP_WRITE, 32'hFFFF_FFE0);
    send_access(OP_READ,  32'h8000_0000);
    send_access(OP_WRITE, 32'h7FFF_FFFF);
    send_access(OP_READ,  32'hAAAA_AAAA);
    send_access(OP_WRITE, 32'h5555_5555);
    send_access(OP_READ,  32'h0000_0000);
    send_access(OP_WRITE, 32'h0000_0000);
    in_tvalid <= 1'b0;
  endtask

  // main sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_phase(4'd5,  4'd8,  0,  0,  1'b0);
    run_phase(4'd0,  4'd0,  62, 0,  1'b0);
    run_phase(4'd10, 4'd8,  0,  62, 1'b0);
    run_phase(4'd15, 4'd15, 27, 27, 1'b0);
    run_phase(4'd4,  4'd2,  0,  0,  1'b1);
    run_phase(4'd7,  4'd3,  62, 0,  1'b0);
    run_phase(4'd11, 4'd12, 0,  62, 1'b0);
    run_phase(4'd2,  4'd5,  27, 27, 1'b0);
    run_phase(4'd5,  4'd8,  0,  0,  1'b0);
    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== set_assoc_cache_lru_wb.f =====
src/sacl_pkg.sv
src/sacl_stats.sv
src/set_assoc_cache_lru_wb.sv
src/sacl_checker.sv
bench/set_assoc_cache_lru_wb_tb.sv
